@@ design/mbb_pkg.sv @@
// ----------------------------------------------------------------------------
// MSB-first bit buffer package
// Shared widths, function codes and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package mbb_pkg;

    localparam int VALUE_W  = 23;
    localparam int COUNT_W  = 5;
    localparam int BW_W     = 16;
    localparam int WORD_W   = 32;
    localparam int MAX_BITS = 23;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic prep;
        logic wr_byte;
        logic rd_byte;
        logic rd_fin;
        logic out_load;
    } mbb_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_read;
        logic skip;
        logic last_byte;
    } mbb_sts_t;

endpackage

@@ design/mbb_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or write per cycle, registered read data.
// ----------------------------------------------------------------------------
module mbb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

@@ design/mbb_ctrl.sv @@
// ----------------------------------------------------------------------------
// MSB-first bit buffer controller
// Sequences one word at a time through prepare, byte access and output.
// ----------------------------------------------------------------------------
module mbb_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    output mbb_pkg::mbb_cmd_t cmd,
    input  mbb_pkg::mbb_sts_t sts
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_PREP     = 3'd1;
    localparam logic [2:0] S_WR       = 3'd2;
    localparam logic [2:0] S_RD       = 3'd3;
    localparam logic [2:0] S_RD_DRAIN = 3'd4;
    localparam logic [2:0] S_RD_FIN   = 3'd5;
    localparam logic [2:0] S_DONE     = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       m_valid_reg;
    logic       m_valid_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = S_PREP;
                end
            end
            S_PREP: begin
                cmd.prep = 1'b1;
                if (sts.skip) begin
                    state_next = S_DONE;
                end else if (sts.is_read) begin
                    state_next = S_RD;
                end else begin
                    state_next = S_WR;
                end
            end
            S_WR: begin
                cmd.wr_byte = 1'b1;
                if (sts.last_byte) begin
                    state_next = S_DONE;
                end
            end
            S_RD: begin
                cmd.rd_byte = 1'b1;
                if (sts.last_byte) begin
                    state_next = S_RD_DRAIN;
                end
            end
            S_RD_DRAIN: begin
                state_next = S_RD_FIN;
            end
            S_RD_FIN: begin
                cmd.rd_fin = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

endmodule

@@ design/mbb_dpath.sv @@
// ----------------------------------------------------------------------------
// MSB-first bit buffer datapath
// Bit positions, the byte store, word assembly and the output register.
// ----------------------------------------------------------------------------
module mbb_dpath #(
    parameter int STORE_BYTES = 4096
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  mbb_pkg::mbb_cmd_t             cmd,
    output mbb_pkg::mbb_sts_t             sts,
    input  logic                          s_func,
    input  logic [mbb_pkg::VALUE_W-1:0]   s_value,
    input  logic [mbb_pkg::COUNT_W-1:0]   s_count,
    output logic [mbb_pkg::VALUE_W-1:0]   m_read_value,
    output logic [mbb_pkg::BW_W-1:0]      m_bits_written,
    output logic                          m_overflow
);

    localparam int POS_W = $clog2(STORE_BYTES * 8 + 1);
    localparam int AW    = $clog2(STORE_BYTES);
    localparam int WW    = mbb_pkg::WORD_W;
    localparam logic [POS_W:0] CAP = (POS_W + 1)'(STORE_BYTES * 8);
    localparam logic [mbb_pkg::COUNT_W-1:0] MAXB = mbb_pkg::COUNT_W'(mbb_pkg::MAX_BITS);

    logic                        func_reg;
    logic [mbb_pkg::VALUE_W-1:0] value_reg;
    logic [mbb_pkg::COUNT_W-1:0] n_reg;
    logic [POS_W-1:0]            wpos_reg;
    logic [POS_W-1:0]            rpos_reg;
    logic [7:0]                  tail_reg;
    logic [WW-1:0]               word_reg;
    logic [WW-1:0]               mask_reg;
    logic [5:0]                  rshift_reg;
    logic [1:0]                  nb_last_reg;
    logic [1:0]                  k_reg;
    logic [AW-1:0]               base_reg;
    logic                        ovf_reg;
    logic [mbb_pkg::VALUE_W-1:0] res_reg;
    logic                        cap_valid_reg;
    logic [1:0]                  cap_idx_reg;
    logic [mbb_pkg::VALUE_W-1:0] m_read_value_reg;
    logic [mbb_pkg::BW_W-1:0]    m_bits_written_reg;
    logic                        m_overflow_reg;

    logic                        is_read;
    logic                        n_zero;
    logic [2:0]                  off;
    logic [4:0]                  offn;
    logic [POS_W:0]              wsum;
    logic [POS_W:0]              rsum;
    logic                        wovf;
    logic                        rovf;
    logic [1:0]                  nb_last;
    logic [WW-1:0]               lowmask;
    logic [5:0]                  vshift;
    logic [WW-1:0]               word_w;
    logic [POS_W-1:0]            diff;
    logic [mbb_pkg::COUNT_W-1:0] vcnt;
    logic [WW-1:0]               rmask;
    logic [POS_W-1:0]            rpos_sat;
    logic [AW-1:0]               addr;
    logic [7:0]                  wr_data;
    logic [7:0]                  rd_data;
    logic [7:0]                  tail_new;

    assign is_read = (func_reg == mbb_pkg::FUNC_READ);
    assign n_zero  = (n_reg == '0);
    assign off     = is_read ? rpos_reg[2:0] : wpos_reg[2:0];
    assign offn    = 5'(off) + n_reg;
    assign wsum    = (POS_W + 1)'(wpos_reg) + (POS_W + 1)'(n_reg);
    assign rsum    = (POS_W + 1)'(rpos_reg) + (POS_W + 1)'(n_reg);
    assign wovf    = (wsum > CAP);
    assign rovf    = (rsum > {1'b0, wpos_reg});
    assign nb_last = 2'((offn - 5'd1) >> 3);

    // Write word: kept bits of the partial tail byte, then the new field.
    assign lowmask = (WW'(1) << n_reg) - WW'(1);
    assign vshift  = 6'd32 - 6'(off) - 6'(n_reg);
    assign word_w  = ({tail_reg, 24'd0} & ~({WW{1'b1}} >> off))
                   | ((WW'(value_reg) & lowmask) << vshift);

    // Read: only the bits below the write position are valid.
    assign diff = wpos_reg - rpos_reg;
    always_comb begin
        if (wpos_reg > rpos_reg) begin
            if (diff < POS_W'(n_reg)) begin
                vcnt = mbb_pkg::COUNT_W'(diff);
            end else begin
                vcnt = n_reg;
            end
        end else begin
            vcnt = '0;
        end
    end
    assign rmask    = ~({WW{1'b1}} >> vcnt) >> off;
    assign rpos_sat = (rsum > CAP) ? POS_W'(CAP) : POS_W'(rsum);

    assign addr = AW'(base_reg + AW'(k_reg));

    always_comb begin
        case (k_reg)
            2'd0:    wr_data = word_reg[31:24];
            2'd1:    wr_data = word_reg[23:16];
            2'd2:    wr_data = word_reg[15:8];
            default: wr_data = word_reg[7:0];
        endcase
    end

    always_comb begin
        case (offn[4:3])
            2'd0:    tail_new = word_reg[31:24];
            2'd1:    tail_new = word_reg[23:16];
            2'd2:    tail_new = word_reg[15:8];
            default: tail_new = word_reg[7:0];
        endcase
    end

    mbb_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .aclk  (aclk),
        .we    (cmd.wr_byte),
        .addr  (addr),
        .wdata (wr_data),
        .rdata (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wpos_reg      <= '0;
            rpos_reg      <= '0;
            k_reg         <= '0;
            cap_valid_reg <= 1'b0;
        end else begin
            cap_valid_reg <= cmd.rd_byte;
            if (cmd.prep) begin
                k_reg <= '0;
                if (is_read && !n_zero) begin
                    rpos_reg <= rpos_sat;
                end
            end
            if (cmd.wr_byte || cmd.rd_byte) begin
                k_reg <= k_reg + 2'd1;
            end
            if (cmd.wr_byte && sts.last_byte) begin
                wpos_reg <= POS_W'(wsum);
            end
        end
    end

    always_ff @(posedge aclk) begin
        cap_idx_reg <= k_reg;
        if (cmd.load_item) begin
            func_reg  <= s_func;
            value_reg <= s_value;
            n_reg     <= (s_count > MAXB) ? MAXB : s_count;
        end
        if (cmd.prep) begin
            base_reg    <= AW'((is_read ? rpos_reg : wpos_reg) >> 3);
            word_reg    <= is_read ? '0 : word_w;
            mask_reg    <= rmask;
            rshift_reg  <= vshift;
            nb_last_reg <= nb_last;
            ovf_reg     <= !n_zero && (is_read ? rovf : wovf);
            res_reg     <= '0;
        end
        if (cmd.wr_byte && sts.last_byte) begin
            tail_reg <= tail_new;
        end
        if (cap_valid_reg) begin
            case (cap_idx_reg)
                2'd0:    word_reg[31:24] <= rd_data;
                2'd1:    word_reg[23:16] <= rd_data;
                2'd2:    word_reg[15:8]  <= rd_data;
                default: word_reg[7:0]   <= rd_data;
            endcase
        end
        if (cmd.rd_fin) begin
            res_reg <= mbb_pkg::VALUE_W'((word_reg & mask_reg) >> rshift_reg);
        end
        if (cmd.out_load) begin
            m_read_value_reg   <= res_reg;
            m_bits_written_reg <= mbb_pkg::BW_W'(wpos_reg);
            m_overflow_reg     <= ovf_reg;
        end
    end

    assign sts.is_read   = is_read;
    assign sts.skip      = n_zero || (!is_read && wovf);
    assign sts.last_byte = (k_reg == nb_last_reg);

    assign m_read_value   = m_read_value_reg;
    assign m_bits_written = m_bits_written_reg;
    assign m_overflow     = m_overflow_reg;

    a_wpos_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, wpos_reg} <= CAP)
        else $error("Write position passed the store capacity.");

    a_rpos_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, rpos_reg} <= CAP)
        else $error("Read position passed the store capacity.");

    a_wpos_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.wr_byte && sts.last_byte) |=> $stable(wpos_reg))
        else $error("Write position moved outside the last byte write.");

    a_one_access: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.wr_byte && cmd.rd_byte))
        else $error("Byte store read and written in the same cycle.");

endmodule

@@ design/msb_first_bit_buffer.sv @@
// ----------------------------------------------------------------------------
// MSB-first bit buffer
// Bit-granular byte store, appended and drained most significant bit first.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake          Payload
// s_        in         s_valid/s_ready    s_func, s_value, s_count
// m_        out        m_valid/m_ready    m_read_value, m_bits_written, m_overflow
//
// Each input word is worked on alone. A word that appends or reads bits
// touches one to four consecutive bytes of the store through its single RAM
// port, one byte per cycle; a read then passes a drain and a finish state
// before its result, and a zero count or a dropped append skips the store.
// Reset clears both bit positions and the handshake state. The store itself
// is not cleared: reads are masked to bits below the write position, so
// unwritten bytes are never seen and no clearing pass is needed.
// A new word is accepted while the previous result still sits in the output
// register; the block only waits when a further result is ready and that
// register has not been taken.
module msb_first_bit_buffer #(
    parameter int STORE_BYTES = 4096
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_func,
    input  logic [mbb_pkg::VALUE_W-1:0] s_value,
    input  logic [mbb_pkg::COUNT_W-1:0] s_count,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [mbb_pkg::VALUE_W-1:0] m_read_value,
    output logic [mbb_pkg::BW_W-1:0]    m_bits_written,
    output logic                        m_overflow
);

    // The controller drives the datapath only through these two bundles.
    mbb_pkg::mbb_cmd_t cmd;
    mbb_pkg::mbb_sts_t sts;

    mbb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    // The datapath owns the bit positions, the byte store and the output
    // register that holds one finished result.
    mbb_dpath #(
        .STORE_BYTES (STORE_BYTES)
    ) u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .s_func         (s_func),
        .s_value        (s_value),
        .s_count        (s_count),
        .m_read_value   (m_read_value),
        .m_bits_written (m_bits_written),
        .m_overflow     (m_overflow)
    );

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// Testbench for the MSB-first bit buffer
// Streams append and read words into the block, predicts every result with a
// bit-level shadow of the store, and checks each result field by field.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    // The block runs with its default store size. About two thousand words
    // are enough to fill it, so appends that no longer fit are seen as well.
    localparam int          STORE_BYTES  = 4096;
    localparam int unsigned CAP_BITS     = STORE_BYTES * 8;
    localparam int          RANDOM_WORDS = 2000;

    // One input word and one result word, as they sit on the ports.
    typedef struct packed {
        logic                        func;
        logic [mbb_pkg::VALUE_W-1:0] value;
        logic [mbb_pkg::COUNT_W-1:0] count;
    } bit_op_t;

    typedef struct packed {
        logic [mbb_pkg::VALUE_W-1:0] read_value;
        logic [mbb_pkg::BW_W-1:0]    bits_written;
        logic                        overflow;
    } bit_result_t;

    logic                        aclk    = 1'b0;
    logic                        aresetn = 1'b0;
    logic                        s_valid = 1'b0;
    logic                        s_ready;
    logic                        s_func  = mbb_pkg::FUNC_WRITE;
    logic [mbb_pkg::VALUE_W-1:0] s_value = '0;
    logic [mbb_pkg::COUNT_W-1:0] s_count = '0;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    logic [mbb_pkg::VALUE_W-1:0] m_read_value;
    logic [mbb_pkg::BW_W-1:0]    m_bits_written;
    logic                        m_overflow;

    msb_first_bit_buffer #(
        .STORE_BYTES(STORE_BYTES)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_value       (s_value),
        .s_count       (s_count),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_read_value  (m_read_value),
        .m_bits_written(m_bits_written),
        .m_overflow    (m_overflow)
    );

    // 4 ns clock period.
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Shadow of the block. The store is kept as a flat array of bits indexed
    // by bit position, which is the same thing as bytes filled MSB first.
    // ------------------------------------------------------------------------
    bit          store_bits [CAP_BITS];
    int unsigned append_pos = 0;
    int unsigned drain_pos  = 0;

    bit_op_t     pending_words    [$];
    bit_result_t expected_results [$];
    int          mismatches = 0;
    int          result_no  = 0;
    int unsigned cycle_no   = 0;
    bit_op_t     next_word;
    bit_result_t got_result;
    bit_result_t want_result;

    // Applies one word to the shadow and returns the result it must produce.
    function automatic bit_result_t apply_bit_op(input bit_op_t w);
        bit_result_t r;
        int unsigned n;
        int unsigned p;
        int unsigned i;
        logic        b;
        r = '0;
        // Counts above the field limit behave as the limit itself.
        n = (w.count > mbb_pkg::MAX_BITS) ? mbb_pkg::MAX_BITS : w.count;
        if (n != 0) begin
            if (w.func == mbb_pkg::FUNC_WRITE) begin
                // An append that does not fit is dropped as a whole.
                if (append_pos + n > CAP_BITS) begin
                    r.overflow = 1'b1;
                end else begin
                    for (i = 0; i < n; i++) begin
                        store_bits[append_pos + i] = w.value[n - 1 - i];
                    end
                    append_pos += n;
                end
            end else begin
                // Bits at or past the append position read as zero.
                for (i = 0; i < n; i++) begin
                    p = drain_pos + i;
                    b = (p < append_pos) ? store_bits[p] : 1'b0;
                    r.read_value = {r.read_value[mbb_pkg::VALUE_W-2:0], b};
                end
                if (drain_pos + n > append_pos) begin
                    r.overflow = 1'b1;
                end
                // The read position keeps moving past the data but stops at
                // the end of the store.
                drain_pos += n;
                if (drain_pos > CAP_BITS) begin
                    drain_pos = CAP_BITS;
                end
            end
        end
        r.bits_written = append_pos[mbb_pkg::BW_W-1:0];
        return r;
    endfunction

    // Queues a word for the driver together with the result it must cause.
    function automatic void queue_bit_op(input logic func,
                                         input logic [mbb_pkg::VALUE_W-1:0] value,
                                         input logic [mbb_pkg::COUNT_W-1:0] count);
        bit_op_t w;
        w.func  = func;
        w.value = value;
        w.count = count;
        pending_words.push_back(w);
        expected_results.push_back(apply_bit_op(w));
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // Both sides run without any idling during this window of cycles, so
    // back-to-back words and results are seen for a long stretch.
    always @(posedge aclk) begin
        cycle_no <= cycle_no + 1;
    end

    function automatic bit take_turn();
        return (cycle_no >= 3000 && cycle_no < 7000) || ($urandom_range(0, 99) >= 32);
    endfunction

    // ------------------------------------------------------------------------
    // Driver. A word is offered whenever the channel is free, unless this
    // cycle is picked as an idle one. Once offered, the word stays on the
    // ports until the block takes it.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_func  <= mbb_pkg::FUNC_WRITE;
            s_value <= '0;
            s_count <= '0;
        end else if (!s_valid || s_ready) begin
            if (pending_words.size() != 0 && take_turn()) begin
                next_word = pending_words.pop_front();
                s_valid <= 1'b1;
                s_func  <= next_word.func;
                s_value <= next_word.value;
                s_count <= next_word.count;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. The result side stalls at random as well. Every result taken
    // is compared with the oldest expectation still waiting.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= take_turn();
            if (m_valid && m_ready) begin
                got_result.read_value   = m_read_value;
                got_result.bits_written = m_bits_written;
                got_result.overflow     = m_overflow;
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with none expected",
                                              result_no));
                end else begin
                    want_result = expected_results.pop_front();
                    if (got_result.read_value !== want_result.read_value) begin
                        report_mismatch($sformatf("result %0d read_value %h, expected %h",
                                                  result_no, got_result.read_value,
                                                  want_result.read_value));
                    end
                    if (got_result.bits_written !== want_result.bits_written) begin
                        report_mismatch($sformatf("result %0d bits_written %0d, expected %0d",
                                                  result_no, got_result.bits_written,
                                                  want_result.bits_written));
                    end
                    if (got_result.overflow !== want_result.overflow) begin
                        report_mismatch($sformatf("result %0d overflow %b, expected %b",
                                                  result_no, got_result.overflow,
                                                  want_result.overflow));
                    end
                end
                result_no <= result_no + 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run. All words are built up front, so every
    // expectation is known before the first word goes out.
    // ------------------------------------------------------------------------
    initial begin
        bit                          do_append;
        logic [mbb_pkg::COUNT_W-1:0] n;

        // Directed words. A read of an empty store, zero counts on both
        // operations, full-width appends of all ones and all zeros, counts
        // above the limit, single bits, then reads that run up to the append
        // position, straddle it and go fully past it.
        queue_bit_op(mbb_pkg::FUNC_READ,  23'h000000, 5'd5);
        queue_bit_op(mbb_pkg::FUNC_WRITE, 23'h7FFFFF, 5'd0);
        queue_bit_op(mbb_pkg::FUNC_READ,  23'h7FFFFF, 5'd0);
        queue_bit_op(mbb_pkg::FUNC_WRITE, 23'h7FFFFF, 5'd23);
        queue_bit_op(mbb_pkg::FUNC_WRITE, 23'h000000, 5'd23);
        queue_bit_op(mbb_pkg::FUNC_WRITE, 23'h555555, 5'd31);
        queue_bit_op(mbb_pkg::FUNC_WRITE, 23'h7FFFFE, 5'd1);
        queue_bit_op(mbb_pkg::FUNC_WRITE, 23'h000001, 5'd1);
        queue_bit_op(mbb_pkg::FUNC_WRITE, 23'h2AAAAA, 5'd24);
        queue_bit_op(mbb_pkg::FUNC_WRITE, 23'h012345, 5'd17);
        queue_bit_op(mbb_pkg::FUNC_READ,  23'h000000, 5'd3);
        queue_bit_op(mbb_pkg::FUNC_READ,  23'h7FFFFF, 5'd23);
        queue_bit_op(mbb_pkg::FUNC_READ,  23'h000000, 5'd31);
        queue_bit_op(mbb_pkg::FUNC_READ,  23'h000000, 5'd1);
        queue_bit_op(mbb_pkg::FUNC_READ,  23'h000000, 5'd1);
        queue_bit_op(mbb_pkg::FUNC_READ,  23'h000000, 5'd16);
        queue_bit_op(mbb_pkg::FUNC_READ,  23'h000000, 5'd23);
        queue_bit_op(mbb_pkg::FUNC_READ,  23'h000000, 5'd23);
        queue_bit_op(mbb_pkg::FUNC_READ,  23'h000000, 5'd8);
        queue_bit_op(mbb_pkg::FUNC_WRITE, 23'h000003, 5'd2);
        queue_bit_op(mbb_pkg::FUNC_READ,  23'h000000, 5'd2);
        queue_bit_op(mbb_pkg::FUNC_WRITE, 23'h7FFFFF, 5'd31);

        // Random words. While a full-width field still fits, appends
        // dominate so that the store fills up; after that reads dominate,
        // while the remaining appends are mostly dropped. Counts lean toward
        // the large end to get there in time.
        for (int k = 0; k < RANDOM_WORDS; k++) begin
            if (append_pos + mbb_pkg::MAX_BITS <= CAP_BITS) begin
                do_append = ($urandom_range(0, 99) < 90);
            end else begin
                do_append = ($urandom_range(0, 99) < 25);
            end
            if ($urandom_range(0, 99) < 85) begin
                n = mbb_pkg::COUNT_W'($urandom_range(20, 31));
            end else begin
                n = mbb_pkg::COUNT_W'($urandom_range(0, 31));
            end
            queue_bit_op(do_append ? mbb_pkg::FUNC_WRITE : mbb_pkg::FUNC_READ,
                         mbb_pkg::VALUE_W'($urandom()), n);
        end

        // Reset is held low from the start, then released.
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Wait for the last result, then allow a few more cycles so that a
        // stray extra result would still be caught.
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        if (mismatches == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    // Watchdog: a correct run takes well under a tenth of this.
    initial begin
        #2_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
design/mbb_pkg.sv
design/mbb_ram.sv
design/mbb_ctrl.sv
design/mbb_dpath.sv
design/msb_first_bit_buffer.sv
bench/tb_top.sv
